FILE: design/modular_exponentiation_unit_assert.svh
// assertion macros shared by the modular exponentiation unit files
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define MEU_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define MEU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MEU_ASSERT(name, clk, rstn, prop, msg)

`define MEU_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: design/meu_pkg.sv
// shared constants and types for the modular exponentiation unit
// no dependencies
package meu_pkg;

  localparam int WORD_WIDTH_DEF = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd2;

  // status of the modular multiplier seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } meu_mul_stat_t;

endpackage

FILE: design/modular_exponentiation_unit.sv
// top level of the modular exponentiation unit: config registers, sequencer, output register
// uses meu_pkg, meu_modmul and the assertion header
//
//  channel | direction | handshake        | payload
//  in_     | request   | in_valid/in_stall | in_action, in_message_word, in_last_word
//  out_    | result    | out_valid/out_stall | out_result_word, out_last_out
//  cfg_    | write     | cfg_we            | cfg_index, cfg_data
//
// one request at a time; the bit-serial multiplier sets the pace
// a zero exponent skips the multiplier and goes straight to the output register
// synchronous active-low reset returns exponents and modulus to 1, no clearing pass
// a new request is taken while a finished result still waits on out_stall
`include "modular_exponentiation_unit_assert.svh"

module modular_exponentiation_unit #(
  parameter int WORD_WIDTH = meu_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [WORD_WIDTH-1:0]         in_message_word,
  input  logic                          in_last_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [WORD_WIDTH-1:0]         out_result_word,
  output logic                          out_last_out,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [meu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_WIDTH-1:0]         cfg_data
);
  import meu_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;  // reduce message word mod n
  localparam logic [2:0] S_SQ   = 3'd2;  // square running value
  localparam logic [2:0] S_ML   = 3'd3;  // multiply by reduced base
  localparam logic [2:0] S_OUT  = 3'd4;  // hand result to output register

  logic [W-1:0]  pub_exp_r, priv_exp_r, mod_r;
  logic [2:0]    state_r, state_nxt;
  logic [W-1:0]  expo_r;       // exponent, scanned msb first by shifting left
  logic [CW-1:0] cnt_r;        // exponent bits still to go
  logic [W-1:0]  base_r;       // message word mod n
  logic [W-1:0]  one_r;        // 1 mod n
  logic [W-1:0]  final_r;
  logic          last_r;
  logic          out_valid_r;
  logic [W-1:0]  out_word_r;
  logic          out_last_r;

  logic          in_accept;
  logic [W-1:0]  expo_sel;
  logic [W-1:0]  one_mod;
  logic          out_load;

  logic          mul_start;
  logic [W-1:0]  mul_a, mul_b;
  logic [W-1:0]  mul_prod;
  meu_mul_stat_t mul_stat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign expo_sel  = in_action ? priv_exp_r : pub_exp_r;
  assign one_mod   = (mod_r == W'(1)) ? '0 : W'(1);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  meu_modmul #(
    .W(W)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (mod_r),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  // sequencer: drives the multiplier the same cycle the previous product lands
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = mul_prod;
    mul_b     = mul_prod;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (expo_sel == '0) begin
            state_nxt = S_OUT;
          end else begin
            // reduction as a multiply: (1 mod n) * word
            mul_start = 1'b1;
            mul_a     = one_mod;
            mul_b     = in_message_word;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = one_r;
          mul_b     = one_r;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_stat.done) begin
          if (expo_r[W-1]) begin
            mul_start = 1'b1;
            mul_a     = base_r;
            state_nxt = S_ML;
          end else if (cnt_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            mul_start = 1'b1;
          end
        end
      end
      S_ML: begin
        if (mul_stat.done) begin
          if (cnt_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            mul_start = 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pub_exp_r   <= W'(1);
      priv_exp_r  <= W'(1);
      mod_r       <= W'(1);
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PUB_EXP:  pub_exp_r  <= cfg_data;
          REG_PRIV_EXP: priv_exp_r <= cfg_data;
          REG_MODULUS: begin
            // a zero modulus is dropped
            if (cfg_data != '0) begin
              mod_r <= cfg_data;
            end
          end
          default: begin
            mod_r <= mod_r;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      expo_r  <= expo_sel;
      last_r  <= in_last_word;
      one_r   <= one_mod;
      final_r <= W'(1);
      cnt_r   <= CW'(W - 1);
    end
    if (state_r == S_RED && mul_stat.done) begin
      base_r <= mul_prod;
    end
    // advance to the next exponent bit after square (bit clear) or multiply
    if (mul_stat.done && cnt_r != '0 &&
        ((state_r == S_SQ && !expo_r[W-1]) || state_r == S_ML)) begin
      expo_r <= {expo_r[W-2:0], 1'b0};
      cnt_r  <= cnt_r - CW'(1);
    end
    if (mul_stat.done && (state_r == S_SQ || state_r == S_ML)) begin
      final_r <= mul_prod;
    end
    if (out_load) begin
      out_word_r <= final_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_last_out    = out_last_r;

  `MEU_ASSERT(a_mod_nonzero, clk, rst_n, mod_r != '0, "modulus became zero")
  `MEU_ASSERT(a_done_in_work, clk, rst_n, mul_stat.done |-> (state_r == S_RED || state_r == S_SQ || state_r == S_ML), "multiplier done outside work states")
  `MEU_ASSERT(a_zero_exp_direct, clk, rst_n, (in_accept && expo_sel == '0) |=> (state_r == S_OUT), "zero exponent not bypassed")
  `MEU_ASSERT(a_out_mul_idle, clk, rst_n, (state_r == S_OUT) |-> !mul_stat.busy, "multiplier busy at result")
  `MEU_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset did not idle")

endmodule

FILE: design/meu_modmul.sv
// bit-serial interleaved modular multiplier: product = op_a * op_b mod modulus
// needs op_a < modulus; op_b any value; uses meu_pkg and the assertion header
`include "modular_exponentiation_unit_assert.svh"

module meu_modmul #(
  parameter int W = meu_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          op_a,
  input  logic [W-1:0]          op_b,
  input  logic [W-1:0]          modulus,
  output meu_pkg::meu_mul_stat_t stat,
  output logic [W-1:0]          product
);
  import meu_pkg::*;

  localparam int SW = W + 3;
  localparam int CW = $clog2(W);

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_SETUP = 2'd1;
  localparam logic [1:0] M_RUN   = 2'd2;

  logic [1:0]           st_r;
  logic [W-1:0]         a_r;
  logic [W-1:0]         n_r;
  logic [W-1:0]         b_r;
  logic [W-1:0]         acc_r;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic signed [SW-1:0] amn_r;
  logic signed [SW-1:0] am2n_r;

  logic signed [SW-1:0] a_s, n_s, d_s, dn_s, x_s, x1_s, x2_s, step_s;
  logic [W-1:0]         acc_nxt;

  // acc < n so 2*acc + a < 3n: pick among the five candidates by sign
  always_comb begin
    a_s  = $signed({3'b000, a_r});
    n_s  = $signed({3'b000, n_r});
    d_s  = $signed({2'b00, acc_r, 1'b0});
    dn_s = d_s - n_s;
    x_s  = d_s + a_s;
    x1_s = d_s + amn_r;
    x2_s = d_s + am2n_r;
    if (b_r[W-1]) begin
      if (!x2_s[SW-1]) begin
        step_s = x2_s;
      end else if (!x1_s[SW-1]) begin
        step_s = x1_s;
      end else begin
        step_s = x_s;
      end
    end else begin
      step_s = dn_s[SW-1] ? d_s : dn_s;
    end
    acc_nxt = step_s[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        M_IDLE: begin
          if (start) begin
            st_r <= M_SETUP;
          end
        end
        M_SETUP: begin
          st_r <= M_RUN;
        end
        M_RUN: begin
          if (cnt_r == '0) begin
            st_r   <= M_IDLE;
            done_r <= 1'b1;
          end
        end
        default: begin
          st_r <= M_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (st_r)
      M_IDLE: begin
        if (start) begin
          a_r   <= op_a;
          b_r   <= op_b;
          n_r   <= modulus;
          acc_r <= '0;
          cnt_r <= CW'(W - 1);
        end
      end
      M_SETUP: begin
        amn_r  <= a_s - n_s;
        am2n_r <= a_s - (n_s <<< 1);
      end
      M_RUN: begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign stat.busy = (st_r != M_IDLE);
  assign stat.done = done_r;
  assign product   = acc_r;

  `MEU_ASSERT(a_mul_start_idle, clk, rst_n, start |-> !stat.busy, "start while busy")
  `MEU_ASSERT(a_mul_reduced, clk, rst_n, done_r |-> (acc_r < n_r), "product not reduced")
  `MEU_ASSERT(a_mul_done_after_run, clk, rst_n, done_r |-> $past(st_r == M_RUN), "stray done")

endmodule

FILE: tb/meu_checker.sv
// result checker for the modular exponentiation unit: mirrors register writes,
// predicts each result from the accepted request and compares it; uses meu_pkg
`timescale 1ns / 1ps

module meu_checker #(
  parameter int W = meu_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_action,
  input  logic [W-1:0]                  in_message_word,
  input  logic                          in_last_word,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [W-1:0]                  out_result_word,
  input  logic                          out_last_out,
  input  logic                          cfg_we,
  input  logic [meu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]                  cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import meu_pkg::*;

  typedef struct packed {
    logic [W-1:0] word;
    logic         last;
  } mod_result_t;

  logic [W-1:0] pub_exp;
  logic [W-1:0] priv_exp;
  logic [W-1:0] modulus;
  mod_result_t  expected_results[$];

  // square and multiply, msb first, products held at twice the word width
  function automatic logic [W-1:0] mod_power(input logic [W-1:0] base,
                                             input logic [W-1:0] expo,
                                             input logic [W-1:0] n);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] b;
    logic [2*W-1:0] nw;
    if (expo == '0) return 1;
    nw  = {{W{1'b0}}, n};
    b   = {{W{1'b0}}, base} % nw;
    acc = 1;
    for (int i = W - 1; i >= 0; i--) begin
      acc = (acc * acc) % nw;
      if (expo[i]) acc = (acc * b) % nw;
    end
    return acc[W-1:0];
  endfunction

  always @(posedge clk) begin
    mod_result_t want;
    if (!rst_n) begin
      pub_exp  <= 1;
      priv_exp <= 1;
      modulus  <= 1;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PUB_EXP:  pub_exp <= cfg_data;
          REG_PRIV_EXP: priv_exp <= cfg_data;
          REG_MODULUS:  if (cfg_data != '0) modulus <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want.word = mod_power(in_message_word, in_action ? priv_exp : pub_exp, modulus);
        want.last = in_last_word;
        // append at the tail of the queue
        expected_results = {expected_results, want};
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h last %b", $time, out_result_word, out_last_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_result_word !== want.word) begin
            $display("%0t: result_word expected %h actual %h", $time, want.word,
                     out_result_word);
            fail_count++;
          end
          if (out_last_out !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, out_last_out);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top for modular_exponentiation_unit: clock, reset, request and register
// stimulus, random stalls and the verdict; checking is done by meu_checker
`timescale 1ns / 1ps

module tb;
  import meu_pkg::*;

  localparam int W = WORD_WIDTH_DEF;

  // action codes and an index that selects no register
  localparam logic ENCRYPT = 1'b0;
  localparam logic DECRYPT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_action;
  logic [W-1:0]         in_message_word;
  logic                 in_last_word;
  logic                 out_valid;
  logic                 out_stall;
  logic [W-1:0]         out_result_word;
  logic                 out_last_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]         cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;

  modular_exponentiation_unit #(.WORD_WIDTH(W)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_message_word (in_message_word),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_word (out_result_word),
    .out_last_out    (out_last_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  meu_checker #(.W(W)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_message_word (in_message_word),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_word (out_result_word),
    .out_last_out    (out_last_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one request: random idle cycles first, then hold valid until taken
  // called and returning at a falling edge
  task automatic send_request(input logic act, input logic [W-1:0] word, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_message_word <= word;
    in_last_word    <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off new requests until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // single register write, strobe lowered on the following cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_keys(input logic [W-1:0] pub, input logic [W-1:0] priv,
                          input logic [W-1:0] n);
    write_reg(REG_PUB_EXP, pub);
    write_reg(REG_PRIV_EXP, priv);
    write_reg(REG_MODULUS, n);
  endtask

  // operand mix: zero, all ones, tiny values, msb set, fully random
  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1, 16);
      3: return {1'b1, {(W-1){1'b0}}} | $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] rand_modulus();
    case ($urandom_range(5))
      0: return 1;
      1: return '1;
      2: return $urandom_range(2, 1000);
      default: return $urandom;
    endcase
  endfunction

  // watchdog, several times the slowest legal run
  initial begin
    #80_000_000;
    $display("modular_exponentiation_unit: mismatch");
    $finish;
  end

  initial begin
    int sent;
    int len;
    bit noisy;
    logic act;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ENCRYPT;
    in_message_word = '0;
    in_last_word    = 1'b0;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PUB_EXP;
    cfg_data        = '0;
    send_idle_pct   = 14;
    recv_idle_pct   = 82;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: exponent one, modulus one, so everything reduces to zero
    send_request(ENCRYPT, '1, 1'b1);
    send_request(DECRYPT, '0, 1'b0);
    drain();

    // zero public exponent gives one, all-ones private exponent and modulus
    set_keys('0, '1, '1);
    send_request(ENCRYPT, '1, 1'b0);
    send_request(DECRYPT, '0, 1'b0);
    send_request(DECRYPT, 1, 1'b0);
    send_request(DECRYPT, '1, 1'b1);
    send_request(DECRYPT, {{(W-1){1'b1}}, 1'b0}, 1'b0);
    send_request(DECRYPT, {1'b1, {(W-1){1'b0}}}, 1'b1);
    drain();

    // zero modulus write is dropped, unused index does nothing
    write_reg(REG_MODULUS, '0);
    write_reg(REG_NONE, 32'h1234_5678);
    send_request(DECRYPT, 32'h1234_5678, 1'b1);
    drain();

    // modulus one: zero exponent still gives one, nonzero gives zero
    set_keys('0, 5, 1);
    send_request(ENCRYPT, 7, 1'b0);
    send_request(DECRYPT, 7, 1'b1);
    drain();

    // toy rsa key pair, round trip plus a word far above the modulus
    set_keys(17, 2753, 3233);
    send_request(ENCRYPT, 65, 1'b0);
    send_request(DECRYPT, 2790, 1'b1);
    send_request(ENCRYPT, '1, 1'b1);
    drain();

    set_keys(1, 2, 2);
    send_request(ENCRYPT, 3, 1'b0);
    send_request(DECRYPT, '1, 1'b1);
    drain();

    // random part: three pacing phases, several key settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 14; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 5; s++) begin
        drain();
        set_keys(rand_word(), rand_word(), rand_modulus());
        // sometimes poke the ignored writes in between
        if ($urandom_range(3) == 0) write_reg(REG_MODULUS, '0);
        if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom);
        sent = 0;
        while (sent < 17) begin
          len   = $urandom_range(1, 6);
          noisy = ($urandom_range(4) == 0);
          act   = $urandom_range(1);
          for (int k = 0; k < len; k++) begin
            // well-formed message: one action, last flag on the final word only; a noisy one draws both at random
            if (noisy) send_request($urandom_range(1), rand_word(), $urandom_range(1));
            else send_request(act, rand_word(), k == len - 1);
            sent++;
          end
          if ($urandom_range(9) == 0) drain();
        end
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("modular_exponentiation_unit: match");
    end else begin
      $display("modular_exponentiation_unit: mismatch");
    end
    $finish;
  end

endmodule
